### src/ppp_pkg.sv
// shared constants and types for the perspective point projector
`timescale 1ns / 1ps
package ppp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_Z_LOW  = 3'd4,
    REG_Z_HIGH = 3'd5
  } cfg_reg_t;

  localparam int CFG_W   = 24;
  localparam int SPAN_W  = CFG_W + 1;
  localparam int NORM_W  = 16;
  localparam int NQUO_W  = 16;
  localparam int REL_W   = 18;
  localparam int BASIS_W = 17;
  localparam int PROD_W  = REL_W + BASIS_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int GAIN_W  = 10;
  localparam int SCR_W   = 24;

  // camera position, q4.14
  localparam logic signed [REL_W-1:0] CAM_X = 18'sd57344;
  localparam logic signed [REL_W-1:0] CAM_Y = -18'sd26214;
  localparam logic signed [REL_W-1:0] CAM_Z = 18'sd16384;

  // camera basis, q16
  localparam logic signed [BASIS_W-1:0] BU_X = 17'sd37582;
  localparam logic signed [BASIS_W-1:0] BU_Y = 17'sd53689;
  localparam logic signed [BASIS_W-1:0] BU_Z = 17'sd0;
  localparam logic signed [BASIS_W-1:0] BV_X = -17'sd14143;
  localparam logic signed [BASIS_W-1:0] BV_Y = 17'sd9900;
  localparam logic signed [BASIS_W-1:0] BV_Z = 17'sd63221;
  localparam logic signed [BASIS_W-1:0] BW_X = -17'sd51793;
  localparam logic signed [BASIS_W-1:0] BW_Y = 17'sd36255;
  localparam logic signed [BASIS_W-1:0] BW_Z = -17'sd17264;

  // zoom times page scale
  localparam logic [GAIN_W-1:0] GAIN = 10'd1000;

endpackage

### src/ppp_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ppp_div #(
  parameter int NW = 41,
  parameter int DW = 28,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic          out_ovf,
  output logic [TW-1:0] out_tag
);

  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [RW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic [TW-1:0] tag_r [0:QW];
  logic          vld_r [0:QW];
  logic          ovf_r [1:QW];

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(in_num);
    den_r[0] <= in_den;
    quo_r[0] <= '0;
    tag_r[0] <= in_tag;
  end

  // one quotient bit per stage, msb first
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int K = QW - s;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(den_r[s-1]) << K;
    assign ge = rem_r[s-1] >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? rem_r[s-1] - sh : rem_r[s-1];
      den_r[s] <= den_r[s-1];
      quo_r[s] <= (quo_r[s-1] << 1) | QW'(ge);
      tag_r[s] <= tag_r[s-1];
    end

    // quotient overflow check rides with the first bit
    if (s == 1) begin : g_ovf
      always_ff @(posedge clk) begin
        ovf_r[s] <= rem_r[0] >= (RW'(den_r[0]) << QW);
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign out_quo = quo_r[QW];
  assign out_ovf = ovf_r[QW];
  assign out_tag = tag_r[QW];

endmodule

### src/perspective_point_projector_top.sv
// top level of the perspective point projector pipeline
`timescale 1ns / 1ps
// Perspective point projector: maps a 3-D point to a 2-D page position.
// Input channel: raise start with in_point_x/y/z and in_path_start; a
// transfer happens at each rising edge where start is high and busy is low.
// busy stays low, so a point can be given in every cycle.
// Result channel: out_valid is high for exactly one cycle with
// out_screen_x/y (1/2^OUT_FRAC_BITS point units, saturated), out_move_flag
// and out_depth_fault. The receiver cannot stall; results leave in order.
// Pipeline: stage a, the normalization dividers, stages c to h, the depth
// dividers and the output register, in that order; throughput is one
// point per cycle. Its length is set mostly by the two bit-per-stage dividers:
// 17 stages for axis normalization, 25 for the depth divide.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..5:
// x_low, x_high, y_low, y_high, z_low, z_high); other indexes are ignored.
// Write only while no point is in flight.
// Reset (synchronous, rst_n low) clears the bounds to zero and drops all
// points in flight; no result appears from them.
module perspective_point_projector_top
  import ppp_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic                          in_path_start,
  output logic                          out_valid,
  output logic signed [SCR_W-1:0]       out_screen_x,
  output logic signed [SCR_W-1:0]       out_screen_y,
  output logic                          out_move_flag,
  output logic                          out_depth_fault,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int DIFF_W = ((COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W) + 2;
  localparam int NNUM_W = DIFF_W + 15;
  localparam int NDEN_W = SPAN_W + 3;
  localparam int MAG_W  = DOT_W;
  localparam int MUL_W  = MAG_W + GAIN_W;
  localparam int SNUM_W = MUL_W + OUT_FRAC_BITS;

  // bounds registers
  logic signed [CFG_W-1:0] x_low_r, x_high_r, y_low_r, y_high_r, z_low_r, z_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= '0;
      y_low_r  <= '0;
      y_high_r <= '0;
      z_low_r  <= '0;
      z_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_LOW:  x_low_r  <= cfg_data;
        REG_X_HIGH: x_high_r <= cfg_data;
        REG_Y_LOW:  y_low_r  <= cfg_data;
        REG_Y_HIGH: y_high_r <= cfg_data;
        REG_Z_LOW:  z_low_r  <= cfg_data;
        REG_Z_HIGH: z_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage a: offsets from low bound and spans
  logic                     a_vld_r, a_move_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r, a_dz_r;
  logic signed [SPAN_W-1:0] a_sx_r, a_sy_r, a_sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r   <= DIFF_W'(in_point_x) - DIFF_W'(x_low_r);
    a_dy_r   <= DIFF_W'(in_point_y) - DIFF_W'(y_low_r);
    a_dz_r   <= DIFF_W'(in_point_z) - DIFF_W'(z_low_r);
    a_sx_r   <= SPAN_W'(x_high_r) - SPAN_W'(x_low_r);
    a_sy_r   <= SPAN_W'(y_high_r) - SPAN_W'(y_low_r);
    a_sz_r   <= SPAN_W'(z_high_r) - SPAN_W'(z_low_r);
    a_move_r <= in_path_start;
  end

  // divider operands: magnitudes, z scaled by 2/5
  logic [DIFF_W-1:0] mdx, mdy, mdz;
  logic [SPAN_W-1:0] msx, msy, msz;
  logic [NNUM_W-1:0] nnum_x, nnum_y, nnum_z;
  logic [NDEN_W-1:0] nden_x, nden_y, nden_z;

  always_comb begin
    mdx    = a_dx_r[DIFF_W-1] ? DIFF_W'(-a_dx_r) : DIFF_W'(a_dx_r);
    mdy    = a_dy_r[DIFF_W-1] ? DIFF_W'(-a_dy_r) : DIFF_W'(a_dy_r);
    mdz    = a_dz_r[DIFF_W-1] ? DIFF_W'(-a_dz_r) : DIFF_W'(a_dz_r);
    msx    = a_sx_r[SPAN_W-1] ? SPAN_W'(-a_sx_r) : SPAN_W'(a_sx_r);
    msy    = a_sy_r[SPAN_W-1] ? SPAN_W'(-a_sy_r) : SPAN_W'(a_sy_r);
    msz    = a_sz_r[SPAN_W-1] ? SPAN_W'(-a_sz_r) : SPAN_W'(a_sz_r);
    nnum_x = NNUM_W'(mdx) << 14;
    nnum_y = NNUM_W'(mdy) << 14;
    nnum_z = NNUM_W'(mdz) << 15;
    nden_x = NDEN_W'(msx);
    nden_y = NDEN_W'(msy);
    nden_z = (NDEN_W'(msz) << 2) + NDEN_W'(msz);
  end

  // normalization dividers, y/z tag: {zero span, negative}, x tag: {move, zero span, negative}
  logic              nx_vld, ny_vld, nz_vld;
  logic [NQUO_W-1:0] nx_q, ny_q, nz_q;
  logic              nx_ovf, ny_ovf, nz_ovf;
  logic [2:0]        nx_tag;
  logic [1:0]        ny_tag, nz_tag;

  ppp_div #(.NW(NNUM_W), .DW(NDEN_W), .QW(NQUO_W), .TW(3)) u_div_nx (
    .clk, .rst_n, .in_vld(a_vld_r), .in_num(nnum_x), .in_den(nden_x),
    .in_tag({a_move_r, a_sx_r == '0, a_dx_r[DIFF_W-1] ^ a_sx_r[SPAN_W-1]}),
    .out_vld(nx_vld), .out_quo(nx_q), .out_ovf(nx_ovf), .out_tag(nx_tag)
  );

  ppp_div #(.NW(NNUM_W), .DW(NDEN_W), .QW(NQUO_W), .TW(2)) u_div_ny (
    .clk, .rst_n, .in_vld(a_vld_r), .in_num(nnum_y), .in_den(nden_y),
    .in_tag({a_sy_r == '0, a_dy_r[DIFF_W-1] ^ a_sy_r[SPAN_W-1]}),
    .out_vld(ny_vld), .out_quo(ny_q), .out_ovf(ny_ovf), .out_tag(ny_tag)
  );

  ppp_div #(.NW(NNUM_W), .DW(NDEN_W), .QW(NQUO_W), .TW(2)) u_div_nz (
    .clk, .rst_n, .in_vld(a_vld_r), .in_num(nnum_z), .in_den(nden_z),
    .in_tag({a_sz_r == '0, a_dz_r[DIFF_W-1] ^ a_sz_r[SPAN_W-1]}),
    .out_vld(nz_vld), .out_quo(nz_q), .out_ovf(nz_ovf), .out_tag(nz_tag)
  );

  // signed q2.14 result with saturation
  function automatic logic signed [NORM_W-1:0] norm_sat(
    input logic [NQUO_W-1:0] q,
    input logic              ovf,
    input logic              zero,
    input logic              neg
  );
    logic signed [NORM_W-1:0] res;
    if (zero) begin
      res = '0;
    end else if (neg) begin
      res = (ovf || q > NQUO_W'(32768)) ? -16'sd32768 : NORM_W'(-{1'b0, q});
    end else begin
      res = (ovf || q > NQUO_W'(32767)) ? 16'sd32767 : NORM_W'(q);
    end
    return res;
  endfunction

  // stage c: normalized coordinates
  logic                     c_vld_r, c_move_r;
  logic signed [NORM_W-1:0] c_px_r, c_py_r, c_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= nx_vld & ny_vld & nz_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_px_r   <= norm_sat(nx_q, nx_ovf, nx_tag[1], nx_tag[0]);
    c_py_r   <= norm_sat(ny_q, ny_ovf, ny_tag[1], ny_tag[0]);
    c_pz_r   <= norm_sat(nz_q, nz_ovf, nz_tag[1], nz_tag[0]);
    c_move_r <= nx_tag[2];
  end

  // stage d: relative to camera
  logic                    d_vld_r, d_move_r;
  logic signed [REL_W-1:0] d_rx_r, d_ry_r, d_rz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_rx_r   <= REL_W'(c_px_r) - CAM_X;
    d_ry_r   <= REL_W'(c_py_r) - CAM_Y;
    d_rz_r   <= REL_W'(c_pz_r) - CAM_Z;
    d_move_r <= c_move_r;
  end

  // stage e: basis products
  logic                     e_vld_r, e_move_r;
  logic signed [PROD_W-1:0] e_ux_r, e_uy_r, e_uz_r;
  logic signed [PROD_W-1:0] e_vx_r, e_vy_r, e_vz_r;
  logic signed [PROD_W-1:0] e_wx_r, e_wy_r, e_wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e_ux_r   <= PROD_W'(d_rx_r) * PROD_W'(BU_X);
    e_uy_r   <= PROD_W'(d_ry_r) * PROD_W'(BU_Y);
    e_uz_r   <= PROD_W'(d_rz_r) * PROD_W'(BU_Z);
    e_vx_r   <= PROD_W'(d_rx_r) * PROD_W'(BV_X);
    e_vy_r   <= PROD_W'(d_ry_r) * PROD_W'(BV_Y);
    e_vz_r   <= PROD_W'(d_rz_r) * PROD_W'(BV_Z);
    e_wx_r   <= PROD_W'(d_rx_r) * PROD_W'(BW_X);
    e_wy_r   <= PROD_W'(d_ry_r) * PROD_W'(BW_Y);
    e_wz_r   <= PROD_W'(d_rz_r) * PROD_W'(BW_Z);
    e_move_r <= d_move_r;
  end

  // stage f: dot products
  logic                    f_vld_r, f_move_r;
  logic signed [DOT_W-1:0] f_du_r, f_dv_r, f_dw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f_du_r   <= DOT_W'(e_ux_r) + DOT_W'(e_uy_r) + DOT_W'(e_uz_r);
    f_dv_r   <= DOT_W'(e_vx_r) + DOT_W'(e_vy_r) + DOT_W'(e_vz_r);
    f_dw_r   <= DOT_W'(e_wx_r) + DOT_W'(e_wy_r) + DOT_W'(e_wz_r);
    f_move_r <= e_move_r;
  end

  // stage g: magnitudes, signs and depth check
  logic             g_vld_r, g_move_r, g_fault_r, g_nu_r, g_nv_r;
  logic [MAG_W-1:0] g_mu_r, g_mv_r, g_dep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    g_mu_r    <= f_du_r[DOT_W-1] ? MAG_W'(-f_du_r) : MAG_W'(f_du_r);
    g_mv_r    <= f_dv_r[DOT_W-1] ? MAG_W'(-f_dv_r) : MAG_W'(f_dv_r);
    g_nu_r    <= f_du_r[DOT_W-1];
    g_nv_r    <= f_dv_r[DOT_W-1];
    g_dep_r   <= MAG_W'(f_dw_r);
    g_fault_r <= f_dw_r[DOT_W-1] || (f_dw_r == '0);
    g_move_r  <= f_move_r;
  end

  // stage h: zoom and page scale
  logic             h_vld_r, h_move_r, h_fault_r, h_nu_r, h_nv_r;
  logic [MUL_W-1:0] h_mu_r, h_mv_r;
  logic [MAG_W-1:0] h_dep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    h_mu_r    <= MUL_W'(g_mu_r) * MUL_W'(GAIN);
    h_mv_r    <= MUL_W'(g_mv_r) * MUL_W'(GAIN);
    h_nu_r    <= g_nu_r;
    h_nv_r    <= g_nv_r;
    h_dep_r   <= g_dep_r;
    h_fault_r <= g_fault_r;
    h_move_r  <= g_move_r;
  end

  // projection dividers, x tag: {move, fault, negative}
  logic             sx_vld, sy_vld;
  logic [SCR_W-1:0] sx_q, sy_q;
  logic             sx_ovf, sy_ovf;
  logic [2:0]       sx_tag;
  logic             sy_tag;

  ppp_div #(.NW(SNUM_W), .DW(MAG_W), .QW(SCR_W), .TW(3)) u_div_sx (
    .clk, .rst_n, .in_vld(h_vld_r), .in_num(SNUM_W'(h_mu_r) << OUT_FRAC_BITS),
    .in_den(h_dep_r), .in_tag({h_move_r, h_fault_r, h_nu_r}),
    .out_vld(sx_vld), .out_quo(sx_q), .out_ovf(sx_ovf), .out_tag(sx_tag)
  );

  ppp_div #(.NW(SNUM_W), .DW(MAG_W), .QW(SCR_W), .TW(1)) u_div_sy (
    .clk, .rst_n, .in_vld(h_vld_r), .in_num(SNUM_W'(h_mv_r) << OUT_FRAC_BITS),
    .in_den(h_dep_r), .in_tag(h_nv_r),
    .out_vld(sy_vld), .out_quo(sy_q), .out_ovf(sy_ovf), .out_tag(sy_tag)
  );

  // signed page coordinate with saturation, zero on fault
  function automatic logic signed [SCR_W-1:0] scr_sat(
    input logic [SCR_W-1:0] q,
    input logic             ovf,
    input logic             fault,
    input logic             neg
  );
    logic signed [SCR_W-1:0] res;
    if (fault) begin
      res = '0;
    end else if (neg) begin
      res = (ovf || q > {1'b1, {(SCR_W-1){1'b0}}}) ? {1'b1, {(SCR_W-1){1'b0}}}
                                                   : SCR_W'(-{1'b0, q});
    end else begin
      res = (ovf || q[SCR_W-1]) ? {1'b0, {(SCR_W-1){1'b1}}} : q;
    end
    return res;
  endfunction

  // output register
  logic                    out_vld_r, out_move_r, out_fault_r;
  logic signed [SCR_W-1:0] out_sx_r, out_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= sx_vld & sy_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_sx_r    <= scr_sat(sx_q, sx_ovf, sx_tag[1], sx_tag[0]);
    out_sy_r    <= scr_sat(sy_q, sy_ovf, sx_tag[1], sy_tag);
    out_fault_r <= sx_tag[1];
    out_move_r  <= sx_tag[2];
  end

  assign out_valid       = out_vld_r;
  assign out_screen_x    = out_sx_r;
  assign out_screen_y    = out_sy_r;
  assign out_move_flag   = out_move_r;
  assign out_depth_fault = out_fault_r;

endmodule
